// ----- hdl/paired_read_sv_cluster_assert.svh -----
// Assertion macros shared by the cluster checker.
`ifndef PAIRED_READ_SV_CLUSTER_ASSERT_SVH
`define PAIRED_READ_SV_CLUSTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PRSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/prsc_pkg.sv -----
// Types, codes and helper functions of the read-pair cluster block.
package prsc_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SV_TYPE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUPPORT = 2'd2;

    localparam logic [3:0]  SV_TYPE_RESET     = 4'd0;
    localparam logic [19:0] WINDOW_RESET      = 20'd1000;
    localparam logic [15:0] MIN_SUPPORT_RESET = 16'd2;

    // orientation classes
    localparam logic [3:0] SVT_MAXMATE_MAXCUR = 4'd0;
    localparam logic [3:0] SVT_MINMATE_MINCUR = 4'd1;
    localparam logic [3:0] SVT_MAXMATE_MINCUR = 4'd2;
    localparam logic [3:0] SVT_MINMATE_MAXCUR = 4'd3;
    localparam logic [3:0] SVT_NONE           = 4'd4;
    localparam logic [3:0] SVT_TR_MAXCUR_MAXMATE = 4'd5;
    localparam logic [3:0] SVT_TR_MINCUR_MINMATE = 4'd6;
    localparam logic [3:0] SVT_TR_MAXCUR_MINMATE = 4'd7;
    localparam logic [3:0] SVT_TR_MINCUR_MAXMATE = 4'd8;

    localparam logic [30:0] POS_MAX  = 31'h7FFF_FFFF;
    localparam logic [30:0] CI_FLOOR = 31'd50;
    localparam logic signed [31:0] POS_NONE = -32'sd1;

    typedef struct packed {
        logic [15:0] cur_chrom;
        logic [15:0] mate_chrom;
        logic [30:0] cur_pos;
        logic [15:0] cur_align_len;
        logic [30:0] mate_pos;
        logic [15:0] mate_align_len;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [15:0]        chrom_one;
        logic [15:0]        chrom_two;
        logic signed [31:0] bp_start;
        logic signed [31:0] bp_end;
        logic [15:0]        support;
        logic [30:0]        start_ci;
        logic [30:0]        end_ci;
        logic               run_last;
    } sv_t;

    // queued result: spreads are finished on the way out
    typedef struct packed {
        logic [15:0]        chrom_one;
        logic [15:0]        chrom_two;
        logic signed [31:0] bp_start;
        logic signed [31:0] bp_end;
        logic [15:0]        support;
        logic signed [31:0] high_start;
        logic signed [31:0] low_start;
        logic signed [31:0] high_end;
        logic signed [31:0] low_end;
        logic               run_last;
    } sv_raw_t;

    function automatic logic signed [31:0] sat_end(input logic [30:0] pos,
                                                   input logic [15:0] len);
        logic [31:0] sum;
        sum = {1'b0, pos} + {16'd0, len};
        return sum[31] ? $signed({1'b0, POS_MAX}) : $signed(sum);
    endfunction

    function automatic logic [30:0] ci_of(input logic signed [31:0] hi,
                                          input logic signed [31:0] lo);
        logic signed [32:0] d;
        logic [32:0]        mag;
        logic [30:0]        capped;
        d      = {hi[31], hi} - {lo[31], lo};
        mag    = d[32] ? 33'(-d) : 33'(d);
        capped = (mag > {2'b00, POS_MAX}) ? POS_MAX : mag[30:0];
        return (capped < CI_FLOOR) ? CI_FLOOR : capped;
    endfunction

endpackage

// ----- hdl/paired_read_sv_cluster.sv -----
// Paired-read structural-variant clusterer top level.
// One sorted read-pair record is taken per cycle unless the input register
// holds; it passes through that register into the group state, and a closed
// group is written to the result queue at the same edge as the group state
// update. A record can close up to two groups (a mismatch with the last
// flag set); results queue in a four-entry buffer and the input register holds
// while fewer than two entries are free. With a draining result side the rate
// is one record per cycle as long as records close at most one group each; a
// run of records that each close two groups is paced by the result side at one
// transfer per cycle. Configuration writes are always taken.
module paired_read_sv_cluster
    import prsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 rec_valid,
    output logic                 rec_stall,
    input  rec_t                 rec_data,
    output logic                 sv_valid,
    input  logic                 sv_stall,
    output sv_t                  sv_data
);

    logic [3:0]  sv_type_reg;
    logic [19:0] window_reg;
    logic [15:0] min_support_reg;

    logic        rec_vld_reg;
    rec_t        rec_reg;

    logic               open_reg;
    logic [15:0]        a_cc_reg, a_mc_reg;
    logic [30:0]        a_cp_reg, a_mp_reg;
    logic signed [31:0] rs_reg, re_reg, ls_reg, hs_reg, le_reg, he_reg;
    logic [15:0]        cnt_reg;

    logic               open_next;
    logic [15:0]        a_cc_next, a_mc_next;
    logic [30:0]        a_cp_next, a_mp_next;
    logic signed [31:0] rs_next, re_next, ls_next, hs_next, le_next, he_next;
    logic [15:0]        cnt_next;

    sv_raw_t     fifo_mem [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg;

    logic        advance, accept, pop;
    logic        joins, push_a, push_b;
    sv_raw_t     res_a, res_b, head;

    logic signed [31:0] cp_s, mp_s, ce, me, dc;
    logic [30:0]        dm;
    logic signed [31:0] s_val, e_val, s_acc, e_acc;
    logic               s_max, e_max, hold;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_type_reg     <= SV_TYPE_RESET;
            window_reg      <= WINDOW_RESET;
            min_support_reg <= MIN_SUPPORT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SV_TYPE:     sv_type_reg     <= cfg_data[3:0];
                CFG_WINDOW:      window_reg      <= cfg_data[19:0];
                CFG_MIN_SUPPORT: min_support_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // input register; moves on only with room for two results
    assign advance   = rec_vld_reg && (count_reg <= 3'd2);
    assign rec_stall = rec_vld_reg && !advance;
    assign accept    = rec_valid && !rec_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rec_vld_reg <= 1'b0;
        else if (accept)
            rec_vld_reg <= 1'b1;
        else if (advance)
            rec_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rec_reg <= rec_data;
    end

    // grouping compare
    always_comb
    begin
        cp_s = $signed({1'b0, rec_reg.cur_pos});
        mp_s = $signed({1'b0, rec_reg.mate_pos});
        ce   = sat_end(rec_reg.cur_pos, rec_reg.cur_align_len);
        me   = sat_end(rec_reg.mate_pos, rec_reg.mate_align_len);
        dc   = cp_s - $signed({1'b0, a_cp_reg});
        dm   = (rec_reg.mate_pos >= a_mp_reg) ? rec_reg.mate_pos - a_mp_reg
                                              : a_mp_reg - rec_reg.mate_pos;
        joins = open_reg
             && rec_reg.cur_chrom == a_cc_reg
             && rec_reg.mate_chrom == a_mc_reg
             && dc < $signed({12'd0, window_reg})
             && dm < {11'd0, window_reg};
    end

    // bound selection by orientation class
    always_comb
    begin
        hold  = 1'b0;
        s_val = me;
        s_max = 1'b1;
        e_val = ce;
        e_max = 1'b1;
        unique case (sv_type_reg)
            SVT_MAXMATE_MAXCUR:
            begin
                s_val = me; s_max = 1'b1; e_val = ce;   e_max = 1'b1;
            end
            SVT_MINMATE_MINCUR:
            begin
                s_val = mp_s; s_max = 1'b0; e_val = cp_s; e_max = 1'b0;
            end
            SVT_MAXMATE_MINCUR:
            begin
                s_val = me; s_max = 1'b1; e_val = cp_s; e_max = 1'b0;
            end
            SVT_MINMATE_MAXCUR:
            begin
                s_val = mp_s; s_max = 1'b0; e_val = ce; e_max = 1'b1;
            end
            SVT_NONE:
                hold = 1'b1;
            SVT_TR_MAXCUR_MAXMATE:
            begin
                s_val = ce; s_max = 1'b1; e_val = me; e_max = 1'b1;
            end
            SVT_TR_MAXCUR_MINMATE:
            begin
                s_val = ce; s_max = 1'b1; e_val = mp_s; e_max = 1'b0;
            end
            SVT_TR_MINCUR_MAXMATE:
            begin
                s_val = cp_s; s_max = 1'b0; e_val = me; e_max = 1'b1;
            end
            // unused codes act as the min/min translocation class
            default:
            begin
                s_val = cp_s; s_max = 1'b0; e_val = mp_s; e_max = 1'b0;
            end
        endcase
        if (s_max)
            s_acc = (s_val > rs_reg) ? s_val : rs_reg;
        else
            s_acc = (s_val < rs_reg) ? s_val : rs_reg;
        if (e_max)
            e_acc = (e_val > re_reg) ? e_val : re_reg;
        else
            e_acc = (e_val < re_reg) ? e_val : re_reg;
    end

    // group state update and result build
    always_comb
    begin
        open_next = open_reg;
        a_cc_next = a_cc_reg;
        a_mc_next = a_mc_reg;
        a_cp_next = a_cp_reg;
        a_mp_next = a_mp_reg;
        rs_next   = rs_reg;
        re_next   = re_reg;
        ls_next   = ls_reg;
        hs_next   = hs_reg;
        le_next   = le_reg;
        he_next   = he_reg;
        cnt_next  = cnt_reg;

        if (joins)
        begin
            rs_next  = hold ? rs_reg : s_acc;
            re_next  = hold ? re_reg : e_acc;
            ls_next  = (rs_next < ls_reg) ? rs_next : ls_reg;
            hs_next  = (rs_next > hs_reg) ? rs_next : hs_reg;
            le_next  = (re_next < le_reg) ? re_next : le_reg;
            he_next  = (re_next > he_reg) ? re_next : he_reg;
            cnt_next = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;
        end
        else
        begin
            a_cc_next = rec_reg.cur_chrom;
            a_mc_next = rec_reg.mate_chrom;
            a_cp_next = rec_reg.cur_pos;
            a_mp_next = rec_reg.mate_pos;
            rs_next   = hold ? POS_NONE : s_val;
            re_next   = hold ? POS_NONE : e_val;
            ls_next   = rs_next;
            hs_next   = rs_next;
            le_next   = re_next;
            he_next   = re_next;
            cnt_next  = 16'd1;
        end
        open_next = !rec_reg.last;

        push_a = advance && !joins && open_reg && (cnt_reg >= min_support_reg);
        push_b = advance && rec_reg.last && (cnt_next >= min_support_reg);

        res_a.chrom_one  = a_cc_reg;
        res_a.chrom_two  = a_mc_reg;
        res_a.bp_start   = rs_reg;
        res_a.bp_end     = re_reg;
        res_a.support    = cnt_reg;
        res_a.high_start = hs_reg;
        res_a.low_start  = ls_reg;
        res_a.high_end   = he_reg;
        res_a.low_end    = le_reg;
        res_a.run_last   = !push_b;

        res_b.chrom_one  = a_cc_next;
        res_b.chrom_two  = a_mc_next;
        res_b.bp_start   = rs_next;
        res_b.bp_end     = re_next;
        res_b.support    = cnt_next;
        res_b.high_start = hs_next;
        res_b.low_start  = ls_next;
        res_b.high_end   = he_next;
        res_b.low_end    = le_next;
        res_b.run_last   = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            a_cc_reg <= '0;
            a_mc_reg <= '0;
            a_cp_reg <= '0;
            a_mp_reg <= '0;
            rs_reg   <= POS_NONE;
            re_reg   <= POS_NONE;
            ls_reg   <= POS_NONE;
            hs_reg   <= POS_NONE;
            le_reg   <= POS_NONE;
            he_reg   <= POS_NONE;
            cnt_reg  <= '0;
        end
        else if (advance)
        begin
            open_reg <= open_next;
            a_cc_reg <= a_cc_next;
            a_mc_reg <= a_mc_next;
            a_cp_reg <= a_cp_next;
            a_mp_reg <= a_mp_next;
            rs_reg   <= rs_next;
            re_reg   <= re_next;
            ls_reg   <= ls_next;
            hs_reg   <= hs_next;
            le_reg   <= le_next;
            he_reg   <= he_next;
            cnt_reg  <= cnt_next;
        end
    end

    // result queue
    assign sv_valid = (count_reg != 3'd0);
    assign pop      = sv_valid && !sv_stall;

    always_ff @(posedge clk)
    begin
        if (push_a)
            fifo_mem[wr_ptr_reg] <= res_a;
        if (push_b)
            fifo_mem[push_a ? wr_ptr_reg + 2'd1 : wr_ptr_reg] <= res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + {1'b0, push_a} + {1'b0, push_b};
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_reg + {2'b00, push_a} + {2'b00, push_b}
                        - {2'b00, pop};
        end
    end

    assign head = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        sv_data.chrom_one = head.chrom_one;
        sv_data.chrom_two = head.chrom_two;
        sv_data.bp_start  = head.bp_start;
        sv_data.bp_end    = head.bp_end;
        sv_data.support   = head.support;
        sv_data.start_ci  = ci_of(head.high_start, head.low_start);
        sv_data.end_ci    = ci_of(head.high_end, head.low_end);
        sv_data.run_last  = head.run_last;
    end

endmodule

// ----- hdl/prsc_checker.sv -----
// Port-level checker for the read-pair cluster block, with its bind.
`include "paired_read_sv_cluster_assert.svh"

module prsc_checker
    import prsc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic sv_valid,
    input logic sv_stall,
    input sv_t  sv_data
);

    // a stalled transfer keeps its data
    `PRSC_ASSERT_NEXT(a_hold, clk, rst_n, sv_valid && sv_stall, sv_valid && $stable(sv_data), "result changed while stalled")
    // confidence half-widths never fall under the floor
    `PRSC_ASSERT_NOW(a_ci_floor, clk, rst_n, sv_valid, sv_data.start_ci >= CI_FLOOR && sv_data.end_ci >= CI_FLOOR, "ci below floor")
    // every emitted group holds at least its anchor
    `PRSC_ASSERT_NOW(a_support, clk, rst_n, sv_valid, sv_data.support != 16'd0, "empty group emitted")
    // a result not marked last is followed by the other result of its record
    `PRSC_ASSERT_NEXT(a_pair, clk, rst_n, sv_valid && !sv_stall && !sv_data.run_last, sv_valid, "second result missing")

endmodule

bind paired_read_sv_cluster prsc_checker u_prsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .sv_valid (sv_valid),
    .sv_stall (sv_stall),
    .sv_data  (sv_data)
);
